@@ src/assert_macros.svh @@
// assertion macros for the watchdog rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(lbl, clk_s, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk_s, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk_s, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk_s, rst_n, expr, msg)

`endif

`endif

@@ src/msww_pkg.sv @@
// types and constants of the multi source window watchdog
package msww_pkg;

	localparam int LIMITS_W = 50;
	localparam int NUM_LIMIT_REGS = 6;

	// request codes
	localparam logic [2:0] REQ_TICK    = 3'd0;
	localparam logic [2:0] REQ_START   = 3'd1;
	localparam logic [2:0] REQ_STOP    = 3'd2;
	localparam logic [2:0] REQ_DISABLE = 3'd3;
	localparam logic [2:0] REQ_ENABLE  = 3'd4;

	// configuration register indexes
	localparam logic [2:0] CFG_SAMPLE = 3'd6;
	localparam logic [2:0] CFG_PERIOD = 3'd7;

	// fault causes
	localparam logic [1:0] CAUSE_NONE    = 2'd0;
	localparam logic [1:0] CAUSE_KICK    = 2'd1;
	localparam logic [1:0] CAUSE_RUNNING = 2'd2;
	localparam logic [1:0] CAUSE_WINDOW  = 2'd3;

	// source flag bits
	localparam int FLAG_ACTIVE   = 0;
	localparam int FLAG_RUNNING  = 1;
	localparam int FLAG_DEACT    = 2;
	localparam int FLAG_FORCEOFF = 3;

	localparam logic [7:0]  SAMPLE_RESET = 8'd1;
	localparam logic [15:0] PERIOD_RESET = 16'd1000;

	typedef struct packed {
		logic        scaled;
		logic        single;
		logic [15:0] interval;
		logic [15:0] upper;
		logic [15:0] lower;
	} limits_t;

	localparam limits_t LIMITS_RESET_5000 = 50'h1_0000_1388_0000;
	localparam limits_t LIMITS_RESET_2000 = 50'h1_0000_07D0_0000;
	localparam limits_t LIMITS_RESET_SCALED = 50'h2_0BB8_0BB8_0000;

	// per source state word held in memory
	typedef struct packed {
		logic [3:0]  flags;
		logic [15:0] measured;
		logic [23:0] eff;
	} src_state_t;

	typedef struct packed {
		logic       wr;
		logic [1:0] cause;
	} eval_res_t;

endpackage

@@ src/msww_ram.sv @@
// single port write, single port read memory with registered read data
module msww_ram #(
	parameter int WIDTH = 44,
	parameter int DEPTH = 6,
	parameter int AW = 3
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/msww_eval.sv @@
// per source update and fault check for one transaction
module msww_eval #(
	parameter int TIME_BITS = 32
) (
	input  logic [2:0]                op,
	input  msww_pkg::src_state_t      st_in,
	input  logic [TIME_BITS-1:0]      kick_in,
	input  msww_pkg::limits_t         lim,
	input  logic [TIME_BITS-1:0]      time_now,
	input  logic [7:0]                sample_interval,
	output msww_pkg::src_state_t      st_out,
	output logic [TIME_BITS-1:0]      kick_out,
	output msww_pkg::eval_res_t       res
);

	localparam logic [TIME_BITS-1:0] SAT_MAX = TIME_BITS'(16'hFFFF);

	logic [TIME_BITS-1:0] elapsed;
	logic [23:0]          prod;

	assign elapsed = time_now - kick_in;
	assign prod = 24'(lim.interval) * 24'(sample_interval);

	always_comb begin
		st_out = st_in;
		kick_out = kick_in;
		res.wr = 1'b0;
		res.cause = msww_pkg::CAUSE_NONE;
		case (op)
			msww_pkg::REQ_TICK: begin
				if (st_in.flags[msww_pkg::FLAG_ACTIVE]) begin
					res.wr = 1'b1;
					if (!lim.single && (32'(elapsed) > 32'(st_in.eff))) begin
						res.cause = msww_pkg::CAUSE_KICK;
					end else if (st_in.flags[msww_pkg::FLAG_RUNNING]) begin
						if (32'(elapsed) > 32'(lim.upper)) begin
							res.cause = msww_pkg::CAUSE_RUNNING;
						end
					end else if ((st_in.measured < lim.lower) || (st_in.measured > lim.upper)) begin
						res.cause = msww_pkg::CAUSE_WINDOW;
					end
					if ((res.cause == msww_pkg::CAUSE_NONE) && st_in.flags[msww_pkg::FLAG_DEACT]) begin
						st_out.flags[msww_pkg::FLAG_ACTIVE] = 1'b0;
					end
				end
			end
			msww_pkg::REQ_START: begin
				res.wr = 1'b1;
				if (!st_in.flags[msww_pkg::FLAG_FORCEOFF]) begin
					kick_out = time_now;
					st_out.flags[msww_pkg::FLAG_ACTIVE] = 1'b1;
					st_out.flags[msww_pkg::FLAG_RUNNING] = 1'b1;
					st_out.flags[msww_pkg::FLAG_DEACT] = 1'b0;
				end
			end
			msww_pkg::REQ_STOP: begin
				res.wr = 1'b1;
				st_out.measured = (elapsed > SAT_MAX) ? 16'hFFFF : elapsed[15:0];
				st_out.flags[msww_pkg::FLAG_RUNNING] = 1'b0;
				if (lim.single) begin
					st_out.flags[msww_pkg::FLAG_DEACT] = 1'b1;
				end else if (lim.scaled) begin
					st_out.eff = prod;
				end else begin
					st_out.eff = 24'(lim.interval);
				end
			end
			msww_pkg::REQ_DISABLE: begin
				res.wr = 1'b1;
				st_out.flags[msww_pkg::FLAG_FORCEOFF] = 1'b1;
				st_out.flags[msww_pkg::FLAG_ACTIVE] = 1'b0;
			end
			msww_pkg::REQ_ENABLE: begin
				// clears the force-off and then starts like a normal start
				res.wr = 1'b1;
				kick_out = time_now;
				st_out.flags[msww_pkg::FLAG_FORCEOFF] = 1'b0;
				st_out.flags[msww_pkg::FLAG_ACTIVE] = 1'b1;
				st_out.flags[msww_pkg::FLAG_RUNNING] = 1'b1;
				st_out.flags[msww_pkg::FLAG_DEACT] = 1'b0;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ src/multi_source_window_watchdog.sv @@
// top level of the multi source window watchdog
//
// usage: a transaction is taken on a rising edge with start high and busy low;
// req_type selects tick, start, stop, disable or enable and source_index
// picks the source. every transaction gives exactly one result: done is high
// for one cycle with feed_pulse, tripped, fault_source and fault_cause valid.
// the receiver cannot stall; results are simply presented for that cycle.
// a tick with no check pass, or an ignored transaction, gives its result in
// the cycle after acceptance. a source command runs through ST_RD (read the
// per source memory) and ST_EX (update and write back). a tick that runs a
// check pass walks the sources through the same memory port, each through
// ST_RD and ST_EX in turn, visiting at most NUM_SOURCES of them (the walk
// stops at the first fault). busy is low again in the cycle done is shown, so
// the next transaction may start there. configuration is written through
// cfg_we / cfg_index / cfg_data; the user must do so only while idle, the
// block does not enforce it. reset clears time, trip state and all source
// state at once; no clearing pass is needed.
`include "assert_macros.svh"

module multi_source_window_watchdog #(
	parameter int NUM_SOURCES = 6,
	parameter int TIME_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [2:0]                    req_type,
	input  logic [2:0]                    source_index,
	output logic                          busy,
	output logic                          done,
	output logic                          feed_pulse,
	output logic                          tripped,
	output logic [2:0]                    fault_source,
	output logic [1:0]                    fault_cause,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [msww_pkg::LIMITS_W-1:0] cfg_data
);

	localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int ST_W = $bits(msww_pkg::src_state_t);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SOURCES - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_EX   = 2'd2;

	logic [1:0]           state_q;
	logic [2:0]           op_q;
	logic [IDX_W-1:0]     cur_idx_q;
	logic [TIME_BITS-1:0] time_q;
	logic [15:0]          period_q;
	logic                 trip_q;
	logic [2:0]           trip_src_q;
	logic [1:0]           trip_cause_q;
	logic                 done_q;
	logic                 feed_q;

	msww_pkg::limits_t    limits_q [msww_pkg::NUM_LIMIT_REGS];
	logic [7:0]           sample_q;
	logic [15:0]          period_cfg_q;
	logic [NUM_SOURCES-1:0] valid_q;
	logic [NUM_SOURCES-1:0] eff_raw_q;

	msww_pkg::src_state_t st_rd;
	msww_pkg::src_state_t st_in;
	msww_pkg::src_state_t st_out;
	logic [TIME_BITS-1:0] kick_rd;
	logic [TIME_BITS-1:0] kick_in;
	logic [TIME_BITS-1:0] kick_out;
	msww_pkg::eval_res_t  ev_res;
	msww_pkg::limits_t    lim_cur;
	logic                 mem_we;
	logic [15:0]          pc_inc;
	logic                 pass_due;
	logic                 req_ok;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign feed_pulse = feed_q;
	assign tripped = trip_q;
	assign fault_source = trip_src_q;
	assign fault_cause = trip_cause_q;

	assign lim_cur = limits_q[3'(cur_idx_q)];
	assign pc_inc = period_q + 16'd1;
	assign pass_due = (pc_inc >= period_cfg_q);

	always_comb begin
		req_ok = (req_type inside {[msww_pkg::REQ_START:msww_pkg::REQ_ENABLE]}) &&
			(source_index < 3'(NUM_SOURCES));
	end

	// never-written entries read as reset state; eff follows the raw interval
	// until a stop computes a new one
	always_comb begin
		st_in = st_rd;
		kick_in = kick_rd;
		if (!valid_q[cur_idx_q]) begin
			st_in = '0;
			kick_in = '0;
		end
		if (eff_raw_q[cur_idx_q]) begin
			st_in.eff = 24'(lim_cur.interval);
		end
	end

	assign mem_we = (state_q == ST_EX) && ev_res.wr &&
		((op_q != msww_pkg::REQ_TICK) || (ev_res.cause == msww_pkg::CAUSE_NONE));

	msww_ram #(
		.WIDTH (ST_W),
		.DEPTH (NUM_SOURCES),
		.AW    (IDX_W)
	) u_state_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cur_idx_q),
		.wdata (st_out),
		.raddr (cur_idx_q),
		.rdata (st_rd)
	);

	msww_ram #(
		.WIDTH (TIME_BITS),
		.DEPTH (NUM_SOURCES),
		.AW    (IDX_W)
	) u_kick_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cur_idx_q),
		.wdata (kick_out),
		.raddr (cur_idx_q),
		.rdata (kick_rd)
	);

	msww_eval #(
		.TIME_BITS (TIME_BITS)
	) u_eval (
		.op              (op_q),
		.st_in           (st_in),
		.kick_in         (kick_in),
		.lim             (lim_cur),
		.time_now        (time_q),
		.sample_interval (sample_q),
		.st_out          (st_out),
		.kick_out        (kick_out),
		.res             (ev_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q[0] <= msww_pkg::LIMITS_RESET_5000;
			limits_q[1] <= msww_pkg::LIMITS_RESET_5000;
			limits_q[2] <= msww_pkg::LIMITS_RESET_5000;
			limits_q[3] <= msww_pkg::LIMITS_RESET_2000;
			limits_q[4] <= msww_pkg::LIMITS_RESET_5000;
			limits_q[5] <= msww_pkg::LIMITS_RESET_SCALED;
			sample_q <= msww_pkg::SAMPLE_RESET;
			period_cfg_q <= msww_pkg::PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				msww_pkg::CFG_SAMPLE: sample_q <= cfg_data[7:0];
				msww_pkg::CFG_PERIOD: period_cfg_q <= cfg_data[15:0];
				default: limits_q[cfg_index] <= cfg_data;
			endcase
		end
	end

	// entry valid bits and raw interval marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			eff_raw_q <= '1;
		end else begin
			if (mem_we) begin
				valid_q[cur_idx_q] <= 1'b1;
				eff_raw_q[cur_idx_q] <= 1'b0;
			end
			if (cfg_we && (cfg_index < 3'(NUM_SOURCES))) begin
				eff_raw_q[cfg_index[IDX_W-1:0]] <= 1'b1;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= msww_pkg::REQ_TICK;
			cur_idx_q <= '0;
			time_q <= '0;
			period_q <= '0;
			trip_q <= 1'b0;
			trip_src_q <= '0;
			trip_cause_q <= msww_pkg::CAUSE_NONE;
			done_q <= 1'b0;
			feed_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			feed_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q <= req_type;
						if (req_type == msww_pkg::REQ_TICK) begin
							time_q <= time_q + TIME_BITS'(1);
							if (pass_due) begin
								period_q <= '0;
								if (!trip_q) begin
									cur_idx_q <= '0;
									state_q <= ST_RD;
								end else begin
									done_q <= 1'b1;
								end
							end else begin
								period_q <= pc_inc;
								done_q <= 1'b1;
							end
						end else if (req_ok) begin
							cur_idx_q <= source_index[IDX_W-1:0];
							state_q <= ST_RD;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_EX;
				end
				ST_EX: begin
					if (op_q == msww_pkg::REQ_TICK) begin
						if (ev_res.cause != msww_pkg::CAUSE_NONE) begin
							trip_q <= 1'b1;
							trip_src_q <= 3'(cur_idx_q);
							trip_cause_q <= ev_res.cause;
							done_q <= 1'b1;
							state_q <= ST_IDLE;
						end else if (cur_idx_q == LAST_IDX) begin
							done_q <= 1'b1;
							feed_q <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							cur_idx_q <= cur_idx_q + IDX_W'(1);
							state_q <= ST_RD;
						end
					end else begin
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_PROP(a_done_idle, clk, arst_n, done_q |-> (state_q == ST_IDLE), "result strobe outside idle")
	`ASSERT_PROP(a_trip_sticky, clk, arst_n, trip_q |=> trip_q, "trip latch dropped")
	`ASSERT_NEVER(a_feed_tripped, clk, arst_n, feed_q && trip_q, "feed pulse while tripped")
	`ASSERT_NEVER(a_we_stage, clk, arst_n, mem_we && (state_q != ST_EX), "memory write outside update")
	`ASSERT_PROP(a_cmd_done, clk, arst_n, ((state_q == ST_EX) && (op_q != msww_pkg::REQ_TICK)) |=> done_q, "source command without result")

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the multi source window watchdog
`timescale 1ns / 1ps

module testbench;

	localparam int SRC_COUNT = 6;
	localparam int CYCLE_LIMIT = 500000;
	localparam int CFG_W = msww_pkg::LIMITS_W;
	localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
	localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

	localparam msww_pkg::limits_t RESET_LIMITS_5000 = 50'h1_0000_1388_0000;
	localparam msww_pkg::limits_t RESET_LIMITS_2000 = 50'h1_0000_07D0_0000;
	localparam msww_pkg::limits_t RESET_LIMITS_SCALED = 50'h2_0BB8_0BB8_0000;

	typedef struct packed {
		logic [2:0] req;
		logic [2:0] idx;
	} wd_cmd_t;

	typedef struct packed {
		logic       feed;
		logic       tripped;
		logic [2:0] fsrc;
		logic [1:0] cause;
	} wd_status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] req_type = msww_pkg::REQ_TICK;
	logic [2:0] source_index = 3'd0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = 3'd0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic busy;
	logic done;
	logic feed_pulse;
	logic tripped;
	logic [2:0] fault_source;
	logic [1:0] fault_cause;

	// watchdog mirror: configuration and state
	msww_pkg::limits_t lim_reg [SRC_COUNT];
	logic [7:0] sample_reg;
	logic [15:0] period_reg;
	logic [31:0] now_ticks;
	logic [15:0] period_cnt;
	logic trip_flag;
	logic [2:0] trip_src;
	logic [1:0] trip_cause;
	logic [3:0] src_flags [SRC_COUNT];
	logic [31:0] kick_time [SRC_COUNT];
	logic [15:0] meas [SRC_COUNT];
	logic [23:0] eff_ivl [SRC_COUNT];

	wd_cmd_t pending_cmds [$];
	wd_status_t expected_status [$];
	wd_status_t want_status;
	int gap_pct = 21;
	int mismatch_count = 0;
	int cycle_count = 0;

	multi_source_window_watchdog i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req_type(req_type),
		.source_index(source_index),
		.busy(busy),
		.done(done),
		.feed_pulse(feed_pulse),
		.tripped(tripped),
		.fault_source(fault_source),
		.fault_cause(fault_cause),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void kick_source(int s);
		if (!src_flags[s][msww_pkg::FLAG_FORCEOFF]) begin
			kick_time[s] = now_ticks;
			src_flags[s][msww_pkg::FLAG_ACTIVE] = 1'b1;
			src_flags[s][msww_pkg::FLAG_RUNNING] = 1'b1;
			src_flags[s][msww_pkg::FLAG_DEACT] = 1'b0;
		end
	endfunction

	// walk the active sources in order, latch the first fault
	function automatic logic run_check();
		logic [31:0] el;
		logic [1:0] why;
		for (int s = 0; s < SRC_COUNT; s++) begin
			if (src_flags[s][msww_pkg::FLAG_ACTIVE]) begin
				el = now_ticks - kick_time[s];
				why = msww_pkg::CAUSE_NONE;
				if (!lim_reg[s].single && el > {8'd0, eff_ivl[s]})
					why = msww_pkg::CAUSE_KICK;
				else if (src_flags[s][msww_pkg::FLAG_RUNNING]) begin
					if (el > {16'd0, lim_reg[s].upper})
						why = msww_pkg::CAUSE_RUNNING;
				end else if (meas[s] < lim_reg[s].lower || meas[s] > lim_reg[s].upper) begin
					why = msww_pkg::CAUSE_WINDOW;
				end
				if (why != msww_pkg::CAUSE_NONE) begin
					trip_flag = 1'b1;
					trip_src = 3'(s);
					trip_cause = why;
					return 1'b0;
				end
				if (src_flags[s][msww_pkg::FLAG_DEACT])
					src_flags[s][msww_pkg::FLAG_ACTIVE] = 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic wd_status_t step_watchdog(logic [2:0] req, logic [2:0] idx);
		wd_status_t r;
		logic [31:0] el;
		r.feed = 1'b0;
		if (req == msww_pkg::REQ_TICK) begin
			now_ticks++;
			period_cnt++;
			if (period_cnt >= period_reg) begin
				period_cnt = '0;
				if (!trip_flag)
					r.feed = run_check();
			end
		end else if (idx < SRC_COUNT) begin
			case (req)
				msww_pkg::REQ_START: kick_source(int'(idx));
				msww_pkg::REQ_STOP: begin
					el = now_ticks - kick_time[idx];
					meas[idx] = (el > 32'hFFFF) ? 16'hFFFF : el[15:0];
					src_flags[idx][msww_pkg::FLAG_RUNNING] = 1'b0;
					if (lim_reg[idx].single)
						src_flags[idx][msww_pkg::FLAG_DEACT] = 1'b1;
					else if (lim_reg[idx].scaled)
						eff_ivl[idx] = 24'(lim_reg[idx].interval) * 24'(sample_reg);
					else
						eff_ivl[idx] = 24'(lim_reg[idx].interval);
				end
				msww_pkg::REQ_DISABLE: begin
					src_flags[idx][msww_pkg::FLAG_FORCEOFF] = 1'b1;
					src_flags[idx][msww_pkg::FLAG_ACTIVE] = 1'b0;
				end
				msww_pkg::REQ_ENABLE: begin
					src_flags[idx][msww_pkg::FLAG_FORCEOFF] = 1'b0;
					src_flags[idx][msww_pkg::FLAG_ACTIVE] = 1'b1;
					kick_source(int'(idx));
				end
				default: ;
			endcase
		end
		r.tripped = trip_flag;
		r.fsrc = trip_src;
		r.cause = trip_cause;
		return r;
	endfunction

	task automatic write_register(logic [2:0] idx, logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx < msww_pkg::NUM_LIMIT_REGS) begin
			lim_reg[idx] = data;
			eff_ivl[idx] = 24'(lim_reg[idx].interval);
		end else if (idx == msww_pkg::CFG_SAMPLE) begin
			sample_reg = data[7:0];
		end else if (idx == msww_pkg::CFG_PERIOD) begin
			period_reg = data[15:0];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// loose limits keep well-formed traffic clear of faults, tight ones invite a trip
	task automatic write_limits(bit tight);
		msww_pkg::limits_t lim;
		for (int s = 0; s < SRC_COUNT; s++) begin
			if (tight && $urandom_range(3) == 0) begin
				lim = 50'({$urandom, $urandom});
			end else if (tight) begin
				lim.lower = 16'($urandom_range(10));
				lim.upper = lim.lower + 16'($urandom_range(40));
				lim.interval = 16'($urandom_range(300));
				lim.single = 1'($urandom);
				lim.scaled = 1'($urandom);
			end else begin
				lim.lower = '0;
				lim.upper = ($urandom_range(3) == 0) ? 16'hFFFF :
					16'($urandom_range(40, 16'hFFFF));
				lim.interval = ($urandom_range(3) == 0) ? 16'hFFFF :
					16'($urandom_range(4000, 16'hFFFF));
				lim.single = 1'($urandom);
				lim.scaled = 1'($urandom);
			end
			write_register(3'(s), lim);
		end
	endtask

	task automatic queue_cmd(logic [2:0] req, logic [2:0] idx);
		wd_cmd_t c;
		c.req = req;
		c.idx = idx;
		pending_cmds.push_back(c);
	endtask

	task automatic gen_traffic(int count, bit tight);
		int added;
		int pick;
		int s;
		int n;
		added = 0;
		while (added < count) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				// measurement: start or enable, a run of ticks, stop
				s = $urandom_range(SRC_COUNT - 1);
				queue_cmd($urandom_range(1) ? msww_pkg::REQ_START : msww_pkg::REQ_ENABLE,
					3'(s));
				n = $urandom_range(40);
				repeat (n) queue_cmd(msww_pkg::REQ_TICK, 3'($urandom));
				queue_cmd(msww_pkg::REQ_STOP, 3'(s));
				added += n + 2;
			end else if (pick < 85) begin
				n = $urandom_range(1, 4);
				repeat (n) queue_cmd(msww_pkg::REQ_TICK, 3'($urandom));
				added += n;
			end else begin
				if (tight) begin
					queue_cmd(3'($urandom), 3'($urandom));
				end else begin
					case ($urandom_range(2))
						0: queue_cmd(3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)),
							3'($urandom));
						1: queue_cmd(3'($urandom_range(msww_pkg::REQ_START, REQ_UNUSED_HI)),
							3'($urandom_range(SRC_COUNT, 7)));
						default: queue_cmd(msww_pkg::REQ_DISABLE,
							3'($urandom_range(SRC_COUNT - 1)));
					endcase
				end
				added++;
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_cmds.size() != 0 || start || expected_status.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// driver: hold a transaction until busy is low, then take the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				expected_status.push_back(step_watchdog(req_type, source_index));
			if (!start || !busy) begin
				if (pending_cmds.size() != 0 && int'($urandom_range(99)) >= gap_pct) begin
					start <= 1'b1;
					req_type <= pending_cmds[0].req;
					source_index <= pending_cmds[0].idx;
					pending_cmds.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_status.size() == 0) begin
				$error("result with no transaction pending");
				mismatch_count++;
			end else begin
				want_status = expected_status.pop_front();
				if (feed_pulse !== want_status.feed) begin
					$error("feed_pulse: expected %0d, got %0d", want_status.feed, feed_pulse);
					mismatch_count++;
				end
				if (tripped !== want_status.tripped) begin
					$error("tripped: expected %0d, got %0d", want_status.tripped, tripped);
					mismatch_count++;
				end
				if (fault_source !== want_status.fsrc) begin
					$error("fault_source: expected %0d, got %0d", want_status.fsrc, fault_source);
					mismatch_count++;
				end
				if (fault_cause !== want_status.cause) begin
					$error("fault_cause: expected %0d, got %0d", want_status.cause, fault_cause);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		for (int s = 0; s < SRC_COUNT; s++) begin
			lim_reg[s] = (s == 3) ? RESET_LIMITS_2000 :
				(s == 5) ? RESET_LIMITS_SCALED : RESET_LIMITS_5000;
			src_flags[s] = '0;
			kick_time[s] = '0;
			meas[s] = '0;
			eff_ivl[s] = 24'(lim_reg[s].interval);
		end
		sample_reg = 8'd1;
		period_reg = 16'd1000;
		now_ticks = '0;
		period_cnt = '0;
		trip_flag = 1'b0;
		trip_src = '0;
		trip_cause = msww_pkg::CAUSE_NONE;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed part on the reset limits, a check pass on every tick
		write_register(msww_pkg::CFG_PERIOD, CFG_W'(16'd1));
		@(negedge clk);
		queue_cmd(msww_pkg::REQ_TICK, 3'd0);
		queue_cmd(msww_pkg::REQ_START, 3'd0);
		queue_cmd(msww_pkg::REQ_TICK, 3'd7);
		queue_cmd(msww_pkg::REQ_TICK, 3'd0);
		queue_cmd(msww_pkg::REQ_STOP, 3'd0);
		queue_cmd(msww_pkg::REQ_TICK, 3'd0);
		queue_cmd(msww_pkg::REQ_START, 3'd5);
		queue_cmd(msww_pkg::REQ_TICK, 3'd0);
		queue_cmd(msww_pkg::REQ_STOP, 3'd5);
		queue_cmd(msww_pkg::REQ_TICK, 3'd0);
		queue_cmd(msww_pkg::REQ_ENABLE, 3'd3);
		queue_cmd(msww_pkg::REQ_TICK, 3'd0);
		queue_cmd(msww_pkg::REQ_STOP, 3'd3);
		queue_cmd(msww_pkg::REQ_TICK, 3'd0);
		queue_cmd(msww_pkg::REQ_DISABLE, 3'd2);
		queue_cmd(msww_pkg::REQ_START, 3'd2);
		queue_cmd(msww_pkg::REQ_TICK, 3'd0);
		queue_cmd(msww_pkg::REQ_ENABLE, 3'd2);
		queue_cmd(msww_pkg::REQ_STOP, 3'd2);
		queue_cmd(msww_pkg::REQ_TICK, 3'd0);
		queue_cmd(REQ_UNUSED_LO, 3'd0);
		queue_cmd(REQ_UNUSED_HI, 3'd7);
		queue_cmd(msww_pkg::REQ_START, 3'd6);
		queue_cmd(msww_pkg::REQ_STOP, 3'd7);
		queue_cmd(msww_pkg::REQ_TICK, 3'd0);
		wait_idle();

		// zero period: check on every tick
		write_limits(1'b0);
		write_register(msww_pkg::CFG_SAMPLE, CFG_W'(8'd255));
		write_register(msww_pkg::CFG_PERIOD, CFG_W'(16'd0));
		@(negedge clk);
		gen_traffic(350, 1'b0);
		wait_idle();

		write_register(msww_pkg::CFG_SAMPLE, CFG_W'(8'd1));
		write_register(msww_pkg::CFG_PERIOD, CFG_W'(16'hFFFF));
		@(negedge clk);
		gen_traffic(40, 1'b0);
		wait_idle();

		write_limits(1'b0);
		write_register(msww_pkg::CFG_SAMPLE, CFG_W'(8'($urandom_range(1, 254))));
		write_register(msww_pkg::CFG_PERIOD, CFG_W'(16'($urandom_range(2, 6))));
		@(negedge clk);
		gen_traffic(300, 1'b0);
		wait_idle();

		gap_pct = 86;
		write_register(msww_pkg::CFG_SAMPLE, CFG_W'(8'($urandom_range(1, 255))));
		write_register(msww_pkg::CFG_PERIOD, CFG_W'(16'($urandom_range(1, 3))));
		@(negedge clk);
		gen_traffic(600, 1'b0);
		wait_idle();

		// tight limits, full noise: the trip is expected somewhere in here
		gap_pct = 0;
		write_limits(1'b1);
		case ($urandom_range(2))
			0: write_register(msww_pkg::CFG_SAMPLE, CFG_W'(8'd0));
			1: write_register(msww_pkg::CFG_SAMPLE, CFG_W'(8'd255));
			default: write_register(msww_pkg::CFG_SAMPLE, CFG_W'(8'($urandom)));
		endcase
		write_register(msww_pkg::CFG_PERIOD, CFG_W'(16'($urandom_range(1, 4))));
		@(negedge clk);
		gen_traffic(700, 1'b1);

		repeat (40000) begin
			if (pending_cmds.size() == 0 && !start && expected_status.size() == 0)
				break;
			@(negedge clk);
		end
		repeat (30) @(negedge clk);
		if (expected_status.size() != 0) begin
			$error("%0d results never arrived", expected_status.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+src
src/msww_pkg.sv
src/msww_ram.sv
src/msww_eval.sv
src/multi_source_window_watchdog.sv
sim/testbench.sv
